[hw/rtl/buddy_page_allocator_macros.svh]
// Assertion macros for the buddy page allocator RTL.
// Depends on nothing; included by bpa_seq, the module that carries assertions.
`ifndef BUDDY_PAGE_ALLOCATOR_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BPA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/bpa_pkg.sv]
// Shared constants, types and the frame table reset image for the buddy allocator.
// Depends on nothing; imported by bpa_frame_store, bpa_seq and buddy_page_allocator.
package bpa_pkg;

	localparam int PAGE_COUNT = 64;
	localparam int MAX_ORDER  = 6;
	localparam int PAGE_BYTES = 4096;
	localparam logic [31:0] BASE_RESET = 32'h2000_0000;

	localparam int PW       = $clog2(PAGE_COUNT);
	localparam int PB_SHIFT = $clog2(PAGE_BYTES);
	localparam int ORD_W    = $clog2(MAX_ORDER + 1);
	localparam int CODE_W   = $clog2(2 * MAX_ORDER + 3);

	// Frame codes: free head 0..MAX_ORDER, inner page, used head per order.
	localparam logic [CODE_W-1:0] CODE_FREE_LAST = CODE_W'(MAX_ORDER);
	localparam logic [CODE_W-1:0] CODE_INNER     = CODE_W'(MAX_ORDER + 1);
	localparam logic [CODE_W-1:0] CODE_USED0     = CODE_W'(MAX_ORDER + 2);
	localparam logic [CODE_W-1:0] CODE_USED_LAST = CODE_W'(2 * MAX_ORDER + 2);

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_ORDER = 2'd1,
		ST_NO_SPACE  = 2'd2,
		ST_BAD_FREE  = 2'd3
	} status_t;

	typedef struct packed {
		logic              rd_en;
		logic [PW-1:0]     rd_addr;
		logic              wr_en;
		logic [PW-1:0]     wr_addr;
		logic [CODE_W-1:0] wr_data;
	} ft_req_t;

	typedef logic [CODE_W-1:0] ftab_t [PAGE_COUNT];

	// Tile the region with the largest aligned blocks that fit.
	function automatic ftab_t reset_table();
		ftab_t t;
		int p;
		int k;
		for (int i = 0; i < PAGE_COUNT; i++) begin
			t[i] = CODE_INNER;
		end
		p = 0;
		while (p < PAGE_COUNT) begin
			k = MAX_ORDER;
			while (k > 0 && !(((p & ((1 << k) - 1)) == 0) && (p + (1 << k) <= PAGE_COUNT))) begin
				k = k - 1;
			end
			t[p] = CODE_W'(k);
			p = p + (1 << k);
		end
		return t;
	endfunction

	localparam ftab_t RESET_TABLE = reset_table();

endpackage

[hw/rtl/bpa_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module bpa_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/bpa_frame_store.sv]
// Frame table storage: RAM plus per-page valid bits over the reset image.
// Depends on bpa_pkg and bpa_ram.
module bpa_frame_store (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bpa_pkg::ft_req_t                  req,
	output logic                              rd_valid,
	output logic [bpa_pkg::CODE_W-1:0]        rd_data
);
	import bpa_pkg::*;

	logic [PAGE_COUNT-1:0] written_q;
	logic                  rd_valid_s1;
	logic                  written_s1;
	logic [PW-1:0]         raddr_s1;
	logic [CODE_W-1:0]     ram_rdata;

	bpa_ram #(
		.WIDTH(CODE_W),
		.DEPTH(PAGE_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (req.wr_en),
		.waddr(req.wr_addr),
		.wdata(req.wr_data),
		.re   (req.rd_en),
		.raddr(req.rd_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q   <= '0;
			rd_valid_s1 <= 1'b0;
			written_s1  <= 1'b0;
			raddr_s1    <= '0;
		end else begin
			if (req.wr_en) begin
				written_q[req.wr_addr] <= 1'b1;
			end
			rd_valid_s1 <= req.rd_en;
			if (req.rd_en) begin
				written_s1 <= written_q[req.rd_addr];
				raddr_s1   <= req.rd_addr;
			end
		end
	end

	// An entry never written since reset reads as its reset code.
	assign rd_data  = written_s1 ? ram_rdata : RESET_TABLE[raddr_s1];
	assign rd_valid = rd_valid_s1;

endmodule

[hw/rtl/bpa_seq.sv]
// Request sequencer: frame table scan, split, free check and buddy merge.
// Depends on bpa_pkg and buddy_page_allocator_macros.svh.
`include "buddy_page_allocator_macros.svh"

module bpa_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  logic                       req_type,
	input  logic [3:0]                 block_order,
	input  logic [31:0]                free_address,
	input  logic [31:0]                region_base,
	output bpa_pkg::ft_req_t           ft_req,
	input  logic                       rd_valid,
	input  logic [bpa_pkg::CODE_W-1:0] rd_data,
	output logic                       res_valid,
	input  logic                       res_ready,
	output bpa_pkg::status_t           res_status,
	output logic [31:0]                res_addr
);
	import bpa_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_SPLIT,
		S_FCHK,
		S_FHEAD,
		S_FSTEP,
		S_FBUD,
		S_FEND,
		S_DONE
	} state_t;

	state_t          state_q;
	logic [PW:0]     iss_q;
	logic [PW-1:0]   scan_pg_s1;
	logic            found_q;
	logic [ORD_W-1:0] best_k_q;
	logic [PW-1:0]   best_p_q;
	logic [ORD_W-1:0] order_q;
	logic [31:0]     fa_q;
	logic [PW-1:0]   p_q;
	logic [ORD_W-1:0] k_q;
	status_t         status_q;
	logic [31:0]     addr_q;

	logic            take;
	logic            found_n;
	logic [ORD_W-1:0] best_k_n;
	logic [PW-1:0]   best_p_n;
	logic [31:0]     off;
	logic            off_ok;
	logic [PW-1:0]   buddy;
	logic [PW:0]     bud_end;
	logic            can_merge;
	logic            head_used;
	logic            bud_free;
	logic [PW-1:0]   half_pg;

	// Keep the smallest sufficient free order; ties go to the lower page.
	always_comb begin
		take = (state_q == S_SCAN) && rd_valid
			&& (rd_data <= CODE_FREE_LAST)
			&& (rd_data >= CODE_W'(order_q))
			&& (!found_q || (rd_data < CODE_W'(best_k_q)));
		found_n  = found_q | take;
		best_k_n = take ? rd_data[ORD_W-1:0] : best_k_q;
		best_p_n = take ? scan_pg_s1 : best_p_q;
	end

	always_comb begin
		off       = fa_q - region_base;
		off_ok    = (off[PB_SHIFT-1:0] == '0)
			&& (off[31:PB_SHIFT] < (32 - PB_SHIFT)'(PAGE_COUNT));
		buddy     = p_q ^ (PW'(1) << k_q);
		bud_end   = {1'b0, buddy} + ((PW + 1)'(1) << k_q);
		can_merge = (k_q < ORD_W'(MAX_ORDER)) && (bud_end <= (PW + 1)'(PAGE_COUNT));
		head_used = (rd_data >= CODE_USED0) && (rd_data <= CODE_USED_LAST);
		bud_free  = (rd_data == CODE_W'(k_q));
		half_pg   = p_q + (PW'(1) << ORD_W'(k_q - 1'b1));
	end

	always_comb begin
		ft_req = '0;
		unique case (state_q)
			S_SCAN: begin
				ft_req.rd_en   = (iss_q < (PW + 1)'(PAGE_COUNT));
				ft_req.rd_addr = iss_q[PW-1:0];
			end
			S_FCHK: begin
				ft_req.rd_en   = off_ok;
				ft_req.rd_addr = off[PB_SHIFT +: PW];
			end
			S_FSTEP: begin
				ft_req.rd_en   = can_merge;
				ft_req.rd_addr = buddy;
			end
			S_FBUD: begin
				// Retire the upper head of the merged pair.
				ft_req.wr_en   = bud_free;
				ft_req.wr_addr = (buddy < p_q) ? p_q : buddy;
				ft_req.wr_data = CODE_INNER;
			end
			S_SPLIT: begin
				ft_req.wr_en = 1'b1;
				if (k_q > order_q) begin
					ft_req.wr_addr = half_pg;
					ft_req.wr_data = CODE_W'(ORD_W'(k_q - 1'b1));
				end else begin
					ft_req.wr_addr = p_q;
					ft_req.wr_data = CODE_USED0 + CODE_W'(order_q);
				end
			end
			S_FEND: begin
				ft_req.wr_en   = 1'b1;
				ft_req.wr_addr = p_q;
				ft_req.wr_data = CODE_W'(k_q);
			end
			default: begin
				ft_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			iss_q      <= '0;
			scan_pg_s1 <= '0;
			found_q    <= 1'b0;
			best_k_q   <= '0;
			best_p_q   <= '0;
			order_q    <= '0;
			fa_q       <= '0;
			p_q        <= '0;
			k_q        <= '0;
			status_q   <= ST_OK;
			addr_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						order_q  <= block_order[ORD_W-1:0];
						fa_q     <= free_address;
						iss_q    <= '0;
						found_q  <= 1'b0;
						addr_q   <= '0;
						status_q <= ST_OK;
						if (req_type == REQ_FREE) begin
							state_q <= S_FCHK;
						end else if (block_order > 4'(MAX_ORDER)) begin
							status_q <= ST_BAD_ORDER;
							state_q  <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (ft_req.rd_en) begin
						iss_q      <= iss_q + 1'b1;
						scan_pg_s1 <= iss_q[PW-1:0];
					end
					found_q  <= found_n;
					best_k_q <= best_k_n;
					best_p_q <= best_p_n;
					if (rd_valid && (scan_pg_s1 == PW'(PAGE_COUNT - 1))) begin
						if (found_n) begin
							k_q     <= best_k_n;
							p_q     <= best_p_n;
							state_q <= S_SPLIT;
						end else begin
							status_q <= ST_NO_SPACE;
							state_q  <= S_DONE;
						end
					end
				end
				S_SPLIT: begin
					if (k_q > order_q) begin
						k_q <= ORD_W'(k_q - 1'b1);
					end else begin
						addr_q  <= region_base + (32'(p_q) << PB_SHIFT);
						state_q <= S_DONE;
					end
				end
				S_FCHK: begin
					if (off_ok) begin
						p_q     <= off[PB_SHIFT +: PW];
						state_q <= S_FHEAD;
					end else begin
						status_q <= ST_BAD_FREE;
						state_q  <= S_DONE;
					end
				end
				S_FHEAD: begin
					if (head_used) begin
						k_q     <= ORD_W'(rd_data - CODE_USED0);
						state_q <= S_FSTEP;
					end else begin
						status_q <= ST_BAD_FREE;
						state_q  <= S_DONE;
					end
				end
				S_FSTEP: begin
					state_q <= can_merge ? S_FBUD : S_FEND;
				end
				S_FBUD: begin
					if (bud_free) begin
						if (buddy < p_q) begin
							p_q <= buddy;
						end
						k_q     <= k_q + 1'b1;
						state_q <= S_FSTEP;
					end else begin
						state_q <= S_FEND;
					end
				end
				S_FEND: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_ready  = (state_q == S_IDLE);
	assign res_valid  = (state_q == S_DONE);
	assign res_status = status_q;
	assign res_addr   = addr_q;

	`BPA_ASSERT_NOW(a_no_rw_same_page, clk, arst_n, ft_req.rd_en && ft_req.wr_en, ft_req.rd_addr != ft_req.wr_addr, "frame table read and write hit one page")
	`BPA_ASSERT_NEXT(a_head_read_returns, clk, arst_n, (state_q == S_FCHK) && ft_req.rd_en, rd_valid, "head read data missing")
	`BPA_ASSERT_NEXT(a_buddy_read_returns, clk, arst_n, (state_q == S_FSTEP) && ft_req.rd_en, rd_valid && (state_q == S_FBUD), "buddy read data missing")
	`BPA_ASSERT_NOW(a_split_bounds, clk, arst_n, state_q == S_SPLIT, (k_q >= order_q) && (k_q <= ORD_W'(MAX_ORDER)), "split order out of range")

endmodule

[hw/rtl/buddy_page_allocator.sv]
// Buddy page allocator top level: config register, sequencer, frame store, result register.
// Depends on bpa_pkg, bpa_seq and bpa_frame_store.
//
//  channel  direction  handshake              payload
//  in       sink       in_valid / in_ready    req_type, block_order, free_address
//  out      source     out_valid / out_ready  status, block_address
//  cfg      sink       cfg_valid / cfg_ready  cfg_data (region_base)
//
// One item at a time: in_ready is high only while the sequencer is idle.
// Allocate reads the whole frame table, one page a cycle, then splits the chosen block.
// Free checks the head page, then merges with each buddy that is a free head of equal order.
// A bad order, a bad free address or a page that is not a used head returns an error status.
// Reset loads the reset tiling at once through per-page valid bits; no sweep.
// A finished result waits in the output register; the next item is taken once it is there.
module buddy_page_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [3:0]  block_order,
	input  logic [31:0] free_address,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] block_address,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);
	import bpa_pkg::*;

	logic [31:0]       base_q;
	ft_req_t           ft_req;
	logic              rd_valid;
	logic [CODE_W-1:0] rd_data;
	logic              res_valid;
	logic              res_ready;
	status_t           res_status;
	logic [31:0]       res_addr;
	logic              out_valid_q;
	logic [1:0]        status_q;
	logic [31:0]       addr_q;

	bpa_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (in_valid),
		.req_ready   (in_ready),
		.req_type    (req_type),
		.block_order (block_order),
		.free_address(free_address),
		.region_base (base_q),
		.ft_req      (ft_req),
		.rd_valid    (rd_valid),
		.rd_data     (rd_data),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res_status  (res_status),
		.res_addr    (res_addr)
	);

	bpa_frame_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (ft_req),
		.rd_valid(rd_valid),
		.rd_data (rd_data)
	);

	assign cfg_ready = 1'b1;
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= BASE_RESET;
			out_valid_q <= 1'b0;
			status_q    <= '0;
			addr_q      <= '0;
		end else begin
			if (cfg_valid) begin
				base_q <= cfg_data;
			end
			if (res_ready) begin
				out_valid_q <= res_valid;
				if (res_valid) begin
					status_q <= 2'(res_status);
					addr_q   <= res_addr;
				end
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign block_address = addr_q;

endmodule
